### src/kuznyechik_block_cipher_unit_macros.svh
// Assertion macros for the Kuznyechik cipher unit.
// Used by the top level only.
`ifndef KUZNYECHIK_BLOCK_CIPHER_UNIT_MACROS_SVH
`define KUZNYECHIK_BLOCK_CIPHER_UNIT_MACROS_SVH
// property holds on every clock edge outside reset
`define KZ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication checked in the cycle after the antecedent
`define KZ_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

### src/kuz_pkg.sv
// Shared types, constants and functions of the Kuznyechik cipher unit.
// No dependencies.
`default_nettype none
package kuz_pkg;
  localparam int KeyCount = 10;
  localparam int KeyRounds = 4;
  localparam int StepsPerRound = 8;
  localparam int KeySteps = KeyRounds * StepsPerRound;
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_KEY0 = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY1 = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY2 = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY3 = 2'd3;
  localparam logic REQ_DECRYPT = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_word_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_word_t;

  typedef enum logic [1:0] {
    KS_IDLE,
    KS_RUN
  } ks_state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,
    8'd251,8'd196,8'd250,8'd218,8'd35,8'd197,8'd4,8'd77,
    8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,
    8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,
    8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,
    8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
    8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,
    8'd6,8'd11,8'd237,8'd152,8'd127,8'd212,8'd211,8'd31,
    8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,
    8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,
    8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,
    8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
    8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,
    8'd243,8'd145,8'd120,8'd111,8'd157,8'd158,8'd178,8'd177,
    8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,
    8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,
    8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,
    8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
    8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,
    8'd220,8'd232,8'd40,8'd80,8'd78,8'd51,8'd10,8'd74,
    8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,
    8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,
    8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,
    8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
    8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,
    8'd48,8'd55,8'd107,8'd228,8'd136,8'd217,8'd231,8'd137,
    8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,
    8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,
    8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,
    8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
    8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,
    8'd209,8'd102,8'd175,8'd194,8'd57,8'd75,8'd99,8'd182
  };

  localparam logic [7:0] LCOEF [16] = '{
    8'd148,8'd32,8'd133,8'd16,8'd194,8'd192,8'd1,8'd251,
    8'd1,8'd192,8'd194,8'd16,8'd133,8'd32,8'd148,8'd1
  };

  function automatic logic [7:0] sbox_inv(input logic [7:0] v);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 256; i++) begin
      if (SBOX[i] == v) r = 8'(i);
    end
    return r;
  endfunction

  localparam logic [7:0] POLY_LOW = 8'hc3;

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] x;
    r = '0;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= x;
      x = x[7] ? ((x << 1) ^ POLY_LOW) : (x << 1);
    end
    return r;
  endfunction

  // byte 0 is bits 127:120
  function automatic logic [7:0] lin_comb(input logic [127:0] v);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) r ^= gmul(v[127-8*i -: 8], LCOEF[i]);
    return r;
  endfunction

  // one R step of L: shift right by a byte, new byte 0
  function automatic logic [127:0] r_step(input logic [127:0] b);
    return {lin_comb(b), b[127:8]};
  endfunction

  function automatic logic [127:0] r_inv_step(input logic [127:0] b);
    logic [127:0] v;
    v = {b[119:0], b[127:120]};
    return {b[119:0], lin_comb(v)};
  endfunction

  function automatic logic [127:0] s_layer(input logic [127:0] b);
    logic [127:0] r;
    for (int i = 0; i < 16; i++) r[8*i +: 8] = SBOX[b[8*i +: 8]];
    return r;
  endfunction

  function automatic logic [127:0] s_inv_layer(input logic [127:0] b);
    logic [127:0] r;
    for (int i = 0; i < 16; i++) r[8*i +: 8] = sbox_inv(b[8*i +: 8]);
    return r;
  endfunction

  // full L: sixteen R steps applied in turn
  function automatic logic [127:0] l_full(input logic [127:0] b);
    logic [127:0] r;
    r = b;
    for (int n = 0; n < 16; n++) r = r_step(r);
    return r;
  endfunction

  function automatic logic [127:0] l_inv_full(input logic [127:0] b);
    logic [127:0] r;
    r = b;
    for (int n = 0; n < 16; n++) r = r_inv_step(r);
    return r;
  endfunction

  function automatic logic [127:0] round_const(input logic [5:0] n);
    return l_full({120'd0, 2'b00, n});
  endfunction
endpackage
`default_nettype wire

### src/kuznyechik_block_cipher_unit.sv
// Kuznyechik cipher unit: key schedule sequencer and the pipelined round datapath.
// Depends on kuz_pkg and kuznyechik_block_cipher_unit_macros.svh.
// Reset and every key word write start a schedule that runs one Feistel step per
// cycle (a further write restarts it); blocks are stalled while it runs and in the
// write cycle itself. Otherwise a block enters in every cycle while the result is
// not stalled, and its result is valid after passing through an input register,
// two stages for each of the nine full rounds (key xor with S-box, then L; for
// decryption key xor with inverse L, then inverse S-box) and one stage for the final
// key xor. A stalled result freezes the whole pipe and stalls the input.
`default_nettype none
`include "kuznyechik_block_cipher_unit_macros.svh"
module kuznyechik_block_cipher_unit (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  kuz_pkg::in_word_t                in_data,
  output logic                             out_valid,
  input  wire                              out_stall,
  output kuz_pkg::out_word_t               out_data,
  input  wire                              cfg_we,
  input  wire [kuz_pkg::CfgIdxW-1:0]       cfg_index,
  input  wire [63:0]                       cfg_data
);
  localparam int Stages = 2 * kuz_pkg::KeyCount;

  logic [63:0] key_reg [4];
  logic [127:0] round_key [kuz_pkg::KeyCount];
  logic [127:0] k1, k2, k1_next;
  logic [4:0] step;
  logic [3:0] rk_idx;
  kuz_pkg::ks_state_t state, state_next;
  logic ks_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) key_reg[i] <= '0;
    end else if (cfg_we) begin
      key_reg[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      kuz_pkg::KS_IDLE: if (cfg_we) state_next = kuz_pkg::KS_RUN;
      kuz_pkg::KS_RUN: begin
        if (cfg_we) state_next = kuz_pkg::KS_RUN;
        else if (step == 5'(kuz_pkg::KeySteps - 1)) state_next = kuz_pkg::KS_IDLE;
      end
      default: state_next = kuz_pkg::KS_IDLE;
    endcase
  end

  always_comb begin
    unique case (state)
      kuz_pkg::KS_RUN: ks_busy = 1'b1;
      default:         ks_busy = 1'b0;
    endcase
  end

  assign k1_next = kuz_pkg::l_full(kuz_pkg::s_layer(k1 ^ kuz_pkg::round_const({1'b0, step} + 6'd1)))
                   ^ k2;
  assign rk_idx = {step[4:3], 1'b0} + 4'd2;

  // reset starts a schedule run on the all-zero key
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kuz_pkg::KS_RUN;
      step  <= '0;
    end else begin
      state <= state_next;
      if (cfg_we || state == kuz_pkg::KS_IDLE) step <= '0;
      else step <= step + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k1 <= '0;
      k2 <= '0;
      round_key[0] <= '0;
      round_key[1] <= '0;
    end else if (cfg_we) begin
      k1 <= (cfg_index == kuz_pkg::REG_KEY0) ? {cfg_data, key_reg[1]} :
            (cfg_index == kuz_pkg::REG_KEY1) ? {key_reg[0], cfg_data} : {key_reg[0], key_reg[1]};
      k2 <= (cfg_index == kuz_pkg::REG_KEY2) ? {cfg_data, key_reg[3]} :
            (cfg_index == kuz_pkg::REG_KEY3) ? {key_reg[2], cfg_data} : {key_reg[2], key_reg[3]};
      round_key[0] <= (cfg_index == kuz_pkg::REG_KEY0) ? {cfg_data, key_reg[1]} :
            (cfg_index == kuz_pkg::REG_KEY1) ? {key_reg[0], cfg_data} : {key_reg[0], key_reg[1]};
      round_key[1] <= (cfg_index == kuz_pkg::REG_KEY2) ? {cfg_data, key_reg[3]} :
            (cfg_index == kuz_pkg::REG_KEY3) ? {key_reg[2], cfg_data} : {key_reg[2], key_reg[3]};
    end else if (state == kuz_pkg::KS_RUN) begin
      k1 <= k1_next;
      k2 <= k1;
      if (step[2:0] == 3'd7) begin
        round_key[rk_idx]        <= k1_next;
        round_key[rk_idx + 4'd1] <= k1;
      end
    end
  end

  // pipeline
  logic [Stages-1:0] vld;
  logic [127:0] dat [Stages];
  logic [Stages-2:0] dec;
  logic advance;

  assign advance  = !(out_valid && out_stall);
  assign in_stall = ks_busy || cfg_we || !advance;
  assign out_valid = vld[Stages-1];
  assign out_data  = '{result_high: dat[Stages-1][127:64], result_low: dat[Stages-1][63:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[Stages-2:0], in_valid && !in_stall};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dat[0] <= {in_data.block_high, in_data.block_low};
      dec[0] <= in_data.req_type;
      for (int s = 1; s < Stages - 1; s++) begin
        dec[s] <= dec[s-1];
        if (s % 2 == 1) begin
          // encrypt: key xor + S; decrypt: key xor + L^-1
          if (dec[s-1] == kuz_pkg::REQ_DECRYPT)
            dat[s] <= kuz_pkg::l_inv_full(dat[s-1] ^ round_key[kuz_pkg::KeyCount - 1 - s/2]);
          else
            dat[s] <= kuz_pkg::s_layer(dat[s-1] ^ round_key[s/2]);
        end else begin
          if (dec[s-1] == kuz_pkg::REQ_DECRYPT)
            dat[s] <= kuz_pkg::s_inv_layer(dat[s-1]);
          else
            dat[s] <= kuz_pkg::l_full(dat[s-1]);
        end
      end
      // apply the last round key
      if (dec[Stages-2] == kuz_pkg::REQ_DECRYPT)
        dat[Stages-1] <= dat[Stages-2] ^ round_key[0];
      else
        dat[Stages-1] <= dat[Stages-2] ^ round_key[kuz_pkg::KeyCount - 1];
    end
  end

  `KZ_ASSERT(a_no_accept_busy, !(ks_busy && in_valid && !in_stall), "block accepted during schedule")
  `KZ_ASSERT_NEXT(a_hold_out, out_valid && out_stall, out_valid && $stable(out_data),
                  "stalled result changed")
  `KZ_ASSERT_NEXT(a_step_wrap, state == kuz_pkg::KS_RUN && !cfg_we && step == 5'd31,
                  state == kuz_pkg::KS_IDLE, "schedule overran")
endmodule
`default_nettype wire

### tb/sv/kuznyechik_block_cipher_unit_test.sv
// Self-checking testbench for the Kuznyechik cipher unit: keys, directed and random blocks.
// Holds its own cipher model in a small scoreboard class; depends on kuz_pkg and the unit.
// Random idling on both ports, a long output hold-off and several key settings.
`default_nettype none
module kuznyechik_block_cipher_unit_test;

  class cipher_scoreboard;
    logic [63:0]  key_words[4];
    logic [127:0] round_key[10];
    logic [7:0]   sbox_rev[256];
    kuz_pkg::out_word_t pending[$];
    int           errors;
    int           blocks_checked;

    function new();
      for (int i = 0; i < 256; i++) sbox_rev[kuz_pkg::SBOX[i]] = 8'(i);
      for (int i = 0; i < 4; i++) key_words[i] = '0;
      errors = 0;
      blocks_checked = 0;
      expand();
    endfunction

    function logic [7:0] ff_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] acc;
      logic [8:0] sh;
      acc = '0;
      sh = {1'b0, a};
      for (int i = 0; i < 8; i++) begin
        if (b[i]) acc ^= sh[7:0];
        sh = sh << 1;
        if (sh[8]) sh ^= 9'h1c3;
      end
      return acc;
    endfunction

    function logic [7:0] mix_byte(logic [127:0] v);
      logic [7:0] acc;
      acc = '0;
      for (int i = 0; i < 16; i++) acc ^= ff_mul(v[127 - 8 * i -: 8], kuz_pkg::LCOEF[i]);
      return acc;
    endfunction

    function logic [127:0] lin_fwd(logic [127:0] v);
      logic [127:0] b;
      b = v;
      for (int n = 0; n < 16; n++) b = {mix_byte(b), b[127:8]};
      return b;
    endfunction

    function logic [127:0] lin_back(logic [127:0] v);
      logic [127:0] b;
      logic [127:0] rot;
      b = v;
      for (int n = 0; n < 16; n++) begin
        rot = {b[119:0], b[127:120]};
        b = {b[119:0], mix_byte(rot)};
      end
      return b;
    endfunction

    function logic [127:0] subst(logic [127:0] v, bit back);
      logic [127:0] b;
      for (int i = 0; i < 16; i++)
        b[8 * i +: 8] = back ? sbox_rev[v[8 * i +: 8]] : kuz_pkg::SBOX[v[8 * i +: 8]];
      return b;
    endfunction

    function void expand();
      logic [127:0] k1, k2, c, t;
      k1 = {key_words[0], key_words[1]};
      k2 = {key_words[2], key_words[3]};
      round_key[0] = k1;
      round_key[1] = k2;
      for (int p = 1; p < 5; p++) begin
        for (int j = 1; j <= 8; j++) begin
          c = lin_fwd(128'(8 * (p - 1) + j));
          t = lin_fwd(subst(k1 ^ c, 1'b0)) ^ k2;
          k2 = k1;
          k1 = t;
        end
        round_key[2 * p] = k1;
        round_key[2 * p + 1] = k2;
      end
    endfunction

    function void set_key_word(int idx, logic [63:0] val);
      key_words[idx] = val;
      expand();
    endfunction

    function void note_block(kuz_pkg::in_word_t w);
      logic [127:0] b;
      kuz_pkg::out_word_t r;
      b = {w.block_high, w.block_low};
      if (w.req_type != kuz_pkg::REQ_DECRYPT) begin
        for (int k = 0; k < 9; k++) b = lin_fwd(subst(b ^ round_key[k], 1'b0));
        b ^= round_key[9];
      end else begin
        for (int k = 9; k > 0; k--) b = subst(lin_back(b ^ round_key[k]), 1'b1);
        b ^= round_key[0];
      end
      r.result_high = b[127:64];
      r.result_low = b[63:0];
      pending.push_back(r);
    endfunction

    function void check_block(kuz_pkg::out_word_t got);
      kuz_pkg::out_word_t want;
      blocks_checked++;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.result_high !== want.result_high) begin
        $error("result_high expected %h actual %h", want.result_high, got.result_high);
        errors++;
      end
      if (got.result_low !== want.result_low) begin
        $error("result_low expected %h actual %h", want.result_low, got.result_low);
        errors++;
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  kuz_pkg::in_word_t           in_data;
  logic                        out_valid;
  logic                        out_stall;
  kuz_pkg::out_word_t          out_data;
  logic                        cfg_we;
  logic [kuz_pkg::CfgIdxW-1:0] cfg_index;
  logic [63:0]                 cfg_data;

  cipher_scoreboard sb;
  bit quiet;
  bit long_hold;
  int cycles;
  int blocks_sent;
  int key_writes;

  kuznyechik_block_cipher_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    sb = new();
    rst = 1;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL kuznyechik_block_cipher_unit");
      $finish;
    end
    if (!rst && in_valid && !in_stall) sb.note_block(in_data);
    if (!rst && out_valid && !out_stall) sb.check_block(out_data);
  end

  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        out_stall <= 1;
        repeat (300) @(posedge clk);
        out_stall <= 0;
        long_hold = 0;
        @(posedge clk);
      end else if (quiet || $urandom_range(0, 3) == 0) begin
        out_stall <= 0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        n = $urandom_range(1, 19);
        out_stall <= 1'($urandom_range(0, 1));
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_word(kuz_pkg::in_word_t w);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= w;
    blocks_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic load_key(logic [255:0] k);
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1;
      cfg_index <= kuz_pkg::CfgIdxW'(i);
      cfg_data <= k[255 - 64 * i -: 64];
      sb.set_key_word(i, k[255 - 64 * i -: 64]);
      key_writes++;
      @(posedge clk);
    end
    cfg_we <= 0;
  endtask

  function automatic logic [63:0] rand_half();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_random(int count);
    kuz_pkg::in_word_t w;
    for (int i = 0; i < count; i++) begin
      w.req_type = 1'($urandom_range(0, 1));
      w.block_high = rand_half();
      w.block_low = rand_half();
      send_word(w);
      if (i == count / 2 && $urandom_range(0, 1) == 0) drain();
    end
  endtask

  initial begin
    kuz_pkg::in_word_t w;
    logic [255:0] gost_key;
    logic [255:0] rk;
    gost_key = 256'h8899aabbccddeeff0011223344556677fedcba98765432100123456789abcdef;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_word('{1'b0, 64'h0, 64'h0});
    send_word('{1'b1, 64'h0, 64'h0});
    send_word('{1'b0, '1, '1});
    send_word('{1'b1, '1, '1});
    load_key(gost_key);
    send_word('{1'b0, 64'h1122334455667700, 64'hffeeddccbbaa9988});
    send_word('{1'b1, 64'h7f679d90bebc2430, 64'h5a468d42b9d4edcd});
    send_word('{1'b0, 64'h8000000000000000, 64'h1});
    send_word('{1'b1, 64'h1, 64'h8000000000000000});
    send_word('{1'b0, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555});
    load_key('1);
    send_word('{1'b0, 64'h0, 64'h0});
    send_word('{1'b1, '1, 64'h0});
    drain();
    cfg_we <= 1;
    cfg_index <= kuz_pkg::REG_KEY2;
    cfg_data <= 64'h0123456789abcdef;
    sb.set_key_word(2, 64'h0123456789abcdef);
    key_writes++;
    @(posedge clk);
    cfg_we <= 0;
    send_word('{1'b0, 64'h0123, 64'h4567});
    send_word('{1'b1, 64'h0123, 64'h4567});

    send_random(190);
    rk = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    load_key(rk);
    long_hold = 1;
    send_random(190);
    load_key('0);
    send_random(190);
    rk = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    load_key(rk);
    send_random(190);
    load_key(gost_key);
    send_random(190);
    rk = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    load_key(rk);
    quiet = 1;
    send_random(190);

    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Covered %0d blocks and %0d results under %0d key word writes,",
             blocks_sent, sb.blocks_checked, key_writes);
    $display("both directions, zero/ones/standard/random keys, with stalls and a long hold.");
    if (sb.errors == 0) begin
      $display("PASS kuznyechik_block_cipher_unit");
    end else begin
      $display("FAIL kuznyechik_block_cipher_unit");
    end
    $finish;
  end
endmodule
`default_nettype wire
